/* hw/rtl/rep_pkg.sv */
package rep_pkg;

    localparam logic [15:0] BF16_QNAN = 16'h7FC0;
    localparam logic [7:0]  EXP_MAX   = 8'hFF;

    // Product stage 1 contents
    typedef struct packed {
        logic        sign;
        logic        nan;
        logic        inf;
        logic        zero;
        logic [15:0] m;
        logic [8:0]  esum;
    } mul_s1_t;

    // Adder stage after alignment
    typedef struct packed {
        logic        sign;
        logic        zsign;
        logic        sub;
        logic        nan;
        logic        inf;
        logic        inf_sign;
        logic [7:0]  e;
        logic [26:0] big;
        logic [26:0] sml;
    } add_s3_t;

    // Adder stage after add/subtract
    typedef struct packed {
        logic        sign;
        logic        zsign;
        logic        nan;
        logic        inf;
        logic        inf_sign;
        logic [7:0]  e;
        logic [27:0] sum;
    } add_s4_t;

    // Adder stage after normalization
    typedef struct packed {
        logic        sign;
        logic        zsign;
        logic        zero;
        logic        nan;
        logic        inf;
        logic        inf_sign;
        logic [8:0]  e;
        logic [26:0] n;
    } add_s5_t;

endpackage

/* hw/rtl/rep_mul.sv */
module rep_mul
    import rep_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [15:0] a,
    input  logic [15:0] b,
    output logic [31:0] p
);

    mul_s1_t     s1_next;
    mul_s1_t     s1_reg;
    logic [31:0] p_next;
    logic [31:0] p_reg;

    logic        a_nan, a_inf, a_zero, b_nan, b_inf, b_zero;
    logic [7:0]  ea1, eb1;

    always_comb
    begin
        a_nan  = (a[14:7] == EXP_MAX) && (a[6:0] != 7'd0);
        a_inf  = (a[14:7] == EXP_MAX) && (a[6:0] == 7'd0);
        a_zero = (a[14:0] == 15'd0);
        b_nan  = (b[14:7] == EXP_MAX) && (b[6:0] != 7'd0);
        b_inf  = (b[14:7] == EXP_MAX) && (b[6:0] == 7'd0);
        b_zero = (b[14:0] == 15'd0);
        ea1    = (a[14:7] == 8'd0) ? 8'd1 : a[14:7];
        eb1    = (b[14:7] == 8'd0) ? 8'd1 : b[14:7];
        s1_next.sign = a[15] ^ b[15];
        s1_next.nan  = a_nan | b_nan | (a_inf & b_zero) | (b_inf & a_zero);
        s1_next.inf  = a_inf | b_inf;
        s1_next.zero = a_zero | b_zero;
        s1_next.m    = {(a[14:7] != 8'd0), a[6:0]} * {(b[14:7] != 8'd0), b[6:0]};
        s1_next.esum = {1'b0, ea1} + {1'b0, eb1};
    end

    // Round the exact 16-bit product into single precision
    logic [3:0]         lead;
    logic signed [10:0] ebias;
    logic signed [10:0] k;
    logic [4:0]         rsh;
    logic [23:0]        mn;
    logic [33:0]        full;
    logic [15:0]        q;
    logic [23:0]        frac;

    always_comb
    begin
        lead = 4'd0;
        for (int i = 0; i < 16; i++)
        begin
            if (s1_reg.m[i])
            begin
                lead = 4'(i);
            end
        end
        ebias = $signed({2'b00, s1_reg.esum}) + $signed({7'd0, lead}) - 11'sd141;
        k     = $signed({2'b00, s1_reg.esum}) - 11'sd119;
        mn    = {8'd0, s1_reg.m} << (5'd23 - {1'b0, lead});
        rsh   = (-k > 11'sd17) ? 5'd18 : 5'(-k);
        full  = {s1_reg.m, 18'd0} >> rsh;
        q     = full[33:18];
        frac  = 24'd0;
        if (k >= 0)
        begin
            frac = {8'd0, s1_reg.m} << k[4:0];
        end
        else if (rsh < 5'd18)
        begin
            frac = {8'd0, q} + {23'd0, full[17] & ((|full[16:0]) | q[0])};
        end

        if (s1_reg.nan)
        begin
            p_next = 32'h7FC0_0000;
        end
        else if (s1_reg.inf || ebias >= 11'sd255)
        begin
            p_next = {s1_reg.sign, EXP_MAX, 23'd0};
        end
        else if (s1_reg.zero)
        begin
            p_next = {s1_reg.sign, 31'd0};
        end
        else if (ebias >= 11'sd1)
        begin
            p_next = {s1_reg.sign, ebias[7:0], mn[22:0]};
        end
        else
        begin
            p_next = {s1_reg.sign, 7'd0, frac};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg <= s1_next;
            p_reg  <= p_next;
        end
    end

    assign p = p_reg;

endmodule

/* hw/rtl/rep_add.sv */
module rep_add
    import rep_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [15:0] y
);

    add_s3_t s3_next, s3_reg;
    add_s4_t s4_next, s4_reg;
    add_s5_t s5_next, s5_reg;
    logic [15:0] y_next, y_reg;

    // Align: order by magnitude, shift the smaller operand with sticky
    logic        a_nan, a_inf, b_nan, b_inf, swap;
    logic [31:0] hi, lo;
    logic [7:0]  ehi, elo, d;
    logic [26:0] lo27, mask;

    always_comb
    begin
        a_nan = (a[30:23] == EXP_MAX) && (a[22:0] != 23'd0);
        a_inf = (a[30:23] == EXP_MAX) && (a[22:0] == 23'd0);
        b_nan = (b[30:23] == EXP_MAX) && (b[22:0] != 23'd0);
        b_inf = (b[30:23] == EXP_MAX) && (b[22:0] == 23'd0);
        swap  = b[30:0] > a[30:0];
        hi    = swap ? b : a;
        lo    = swap ? a : b;
        ehi   = (hi[30:23] == 8'd0) ? 8'd1 : hi[30:23];
        elo   = (lo[30:23] == 8'd0) ? 8'd1 : lo[30:23];
        d     = ehi - elo;
        lo27  = {(lo[30:23] != 8'd0), lo[22:0], 3'd0};
        mask  = (27'd1 << d[4:0]) - 27'd1;
        s3_next.sign     = hi[31];
        s3_next.zsign    = a[31] & b[31];
        s3_next.sub      = a[31] ^ b[31];
        s3_next.nan      = a_nan | b_nan | (a_inf & b_inf & (a[31] != b[31]));
        s3_next.inf      = a_inf | b_inf;
        s3_next.inf_sign = a_inf ? a[31] : b[31];
        s3_next.e        = ehi;
        s3_next.big      = {(hi[30:23] != 8'd0), hi[22:0], 3'd0};
        if (d >= 8'd27)
        begin
            s3_next.sml = {26'd0, |lo27};
        end
        else
        begin
            s3_next.sml    = lo27 >> d[4:0];
            s3_next.sml[0] = s3_next.sml[0] | (|(lo27 & mask));
        end
    end

    always_comb
    begin
        s4_next.sign     = s3_reg.sign;
        s4_next.zsign    = s3_reg.zsign;
        s4_next.nan      = s3_reg.nan;
        s4_next.inf      = s3_reg.inf;
        s4_next.inf_sign = s3_reg.inf_sign;
        s4_next.e        = s3_reg.e;
        s4_next.sum      = s3_reg.sub ? ({1'b0, s3_reg.big} - {1'b0, s3_reg.sml})
                                      : ({1'b0, s3_reg.big} + {1'b0, s3_reg.sml});
    end

    // Normalize, never below the minimum exponent
    logic [4:0] lz;
    logic [4:0] sh;
    logic       found;

    always_comb
    begin
        lz    = 5'd27;
        found = 1'b0;
        for (int i = 26; i >= 0; i--)
        begin
            if (s4_reg.sum[i] && !found)
            begin
                lz    = 5'(26 - i);
                found = 1'b1;
            end
        end
        sh = ({3'd0, lz} > (s4_reg.e - 8'd1)) ? 5'(s4_reg.e - 8'd1) : lz;
        s5_next.sign     = s4_reg.sign;
        s5_next.zsign    = s4_reg.zsign;
        s5_next.zero     = (s4_reg.sum == 28'd0);
        s5_next.nan      = s4_reg.nan;
        s5_next.inf      = s4_reg.inf;
        s5_next.inf_sign = s4_reg.inf_sign;
        if (s4_reg.sum[27])
        begin
            s5_next.n = {s4_reg.sum[27:2], |s4_reg.sum[1:0]};
            s5_next.e = {1'b0, s4_reg.e} + 9'd1;
        end
        else
        begin
            s5_next.n = s4_reg.sum[26:0] << sh;
            s5_next.e = {1'b0, s4_reg.e} - {4'd0, sh};
        end
    end

    // Round to nearest even, pack, narrow to bfloat16
    logic [24:0] rm;
    logic [33:0] pw;
    logic [31:0] res;

    always_comb
    begin
        rm  = {1'b0, s5_reg.n[26:3]}
              + {24'd0, s5_reg.n[2] & ((|s5_reg.n[1:0]) | s5_reg.n[3])};
        pw  = {2'b00, s5_reg.e - 9'd1, 23'd0} + {9'd0, rm};
        if (s5_reg.inf)
        begin
            res = {s5_reg.inf_sign, EXP_MAX, 23'd0};
        end
        else if (s5_reg.zero)
        begin
            res = {s5_reg.zsign, 31'd0};
        end
        else if (pw[32:23] >= 10'd255)
        begin
            res = {s5_reg.sign, EXP_MAX, 23'd0};
        end
        else
        begin
            res = {s5_reg.sign, pw[30:0]};
        end
        y_next = s5_reg.nan ? BF16_QNAN : res[31:16];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_reg <= s3_next;
            s4_reg <= s4_next;
            s5_reg <= s5_next;
            y_reg  <= y_next;
        end
    end

    assign y = y_reg;

endmodule

/* hw/rtl/rotary_embed_pair_bf16.sv */
// Throughput: one pair per cycle while the output is not stalled; four product units and two adders run in parallel,
// two stages for each product and four for each sum.
// A stall on the output freezes every stage at once; nothing is dropped or repeated.
// Reset (rst_n, asynchronous, active low) clears only the stage valid bits.
module rotary_embed_pair_bf16
    import rep_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // x_first, x_second, cos_value, sin_value
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata   // y_first, y_second
);

    localparam int DEPTH = 6;

    logic [DEPTH-1:0] vld_reg;
    logic [DEPTH-1:0] vld_next;
    logic             adv;

    logic [31:0] p0c, p1s, p0s, p1c;
    logic [15:0] y0, y1;

    // Advance the whole pipe unless a finished result is held at the output
    assign adv           = !vld_reg[DEPTH-1] || m_axis_tready;
    assign s_axis_tready = adv;
    assign vld_next      = {vld_reg[DEPTH-2:0], s_axis_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    // Four exact products, each rounded to single precision
    rep_mul u_mul_0c (.clk(clk), .en(adv), .a(s_axis_tdata[15:0]),
                      .b(s_axis_tdata[47:32]), .p(p0c));
    rep_mul u_mul_1s (.clk(clk), .en(adv), .a(s_axis_tdata[31:16]),
                      .b(s_axis_tdata[63:48]), .p(p1s));
    rep_mul u_mul_0s (.clk(clk), .en(adv), .a(s_axis_tdata[15:0]),
                      .b(s_axis_tdata[63:48]), .p(p0s));
    rep_mul u_mul_1c (.clk(clk), .en(adv), .a(s_axis_tdata[31:16]),
                      .b(s_axis_tdata[47:32]), .p(p1c));

    // Difference: flip the sign of the subtrahend
    rep_add u_add_y0 (.clk(clk), .en(adv), .a(p0c),
                      .b({~p1s[31], p1s[30:0]}), .y(y0));
    rep_add u_add_y1 (.clk(clk), .en(adv), .a(p0s), .b(p1c), .y(y1));

    assign m_axis_tvalid = vld_reg[DEPTH-1];
    assign m_axis_tdata  = {y1, y0};

    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while output stalled");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> vld_reg[0])
        else $error("accepted pair lost at pipe entry");

    a_nan_canon0: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (y0[14:7] == EXP_MAX) && (y0[6:0] != 7'd0)) |-> (y0 == BF16_QNAN))
        else $error("non-canonical NaN on y_first");

    a_nan_canon1: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (y1[14:7] == EXP_MAX) && (y1[6:0] != 7'd0)) |-> (y1 == BF16_QNAN))
        else $error("non-canonical NaN on y_second");

endmodule

/* sim/rotary_embed_pair_checker.sv */
`timescale 1ns / 100ps

module rotary_embed_pair_checker
    import rep_pkg::*;
(
    input  logic        clk,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,
    output int          fail_count,
    output int          pending,
    output int          rotations_seen
);

    typedef struct packed {
        logic [15:0] y_second;
        logic [15:0] y_first;
    } rot_pair_t;

    rot_pair_t rotated_q[$];

    int fail_total = 0;
    int seen_total = 0;

    // Round m * 2^e to single precision, nearest even, with subnormals.
    function automatic logic [31:0] sp_round(logic sgn, logic [127:0] m, int e);
        int          msb;
        int          lsb_exp;
        int          sh;
        logic [127:0] q;
        logic [127:0] rem_bits;
        logic [127:0] half;
        int          efield;
        begin
            if (m == 0)
                return {sgn, 31'd0};
            msb = 0;
            for (int i = 0; i < 128; i++)
                if (m[i])
                    msb = i;
            lsb_exp = msb + e - 23;
            if (lsb_exp < -149)
                lsb_exp = -149;
            sh = lsb_exp - e;
            if (sh <= 0)
            begin
                q = m << (-sh);
            end
            else if (sh >= 128)
            begin
                q = 0;
            end
            else
            begin
                q        = m >> sh;
                rem_bits = m & ((128'd1 << sh) - 1);
                half     = 128'd1 << (sh - 1);
                if (rem_bits > half || (rem_bits == half && q[0]))
                    q = q + 1;
            end
            if (q[24])
            begin
                q       = q >> 1;
                lsb_exp = lsb_exp + 1;
            end
            if (!q[23])
                return {sgn, 8'd0, q[22:0]};
            efield = lsb_exp + 150;
            if (efield >= 255)
                return {sgn, EXP_MAX, 23'd0};
            return {sgn, efield[7:0], q[22:0]};
        end
    endfunction

    function automatic logic is_nan(logic [31:0] a);
        return a[30:23] == EXP_MAX && a[22:0] != 0;
    endfunction

    function automatic logic is_inf(logic [31:0] a);
        return a[30:23] == EXP_MAX && a[22:0] == 0;
    endfunction

    // Split into integer significand and exponent of its lowest bit.
    function automatic void sp_unpack(logic [31:0] a, output logic [23:0] m, output int e);
        if (a[30:23] == 0)
        begin
            m = {1'b0, a[22:0]};
            e = -149;
        end
        else
        begin
            m = {1'b1, a[22:0]};
            e = int'(a[30:23]) - 150;
        end
    endfunction

    function automatic logic [31:0] sp_mul(logic [31:0] a, logic [31:0] b);
        logic [23:0] ma, mb;
        int          ea, eb;
        logic        sgn;
        begin
            sgn = a[31] ^ b[31];
            if (is_nan(a) || is_nan(b))
                return 32'h7FC0_0000;
            if (is_inf(a) || is_inf(b))
            begin
                if (a[30:0] == 0 || b[30:0] == 0)
                    return 32'h7FC0_0000;
                return {sgn, EXP_MAX, 23'd0};
            end
            sp_unpack(a, ma, ea);
            sp_unpack(b, mb, eb);
            return sp_round(sgn, 128'(ma) * 128'(mb), ea + eb);
        end
    endfunction

    function automatic logic [31:0] sp_add(logic [31:0] a, logic [31:0] b);
        logic [23:0]  ma, mb;
        int           ea, eb;
        int           d;
        int           rs;
        logic [127:0] big_m, sml_m, sum;
        logic         big_s, sml_s, rsgn;
        logic [31:0]  t;
        begin
            if (is_nan(a) || is_nan(b))
                return 32'h7FC0_0000;
            if (is_inf(a) && is_inf(b) && a[31] != b[31])
                return 32'h7FC0_0000;
            if (is_inf(a))
                return a;
            if (is_inf(b))
                return b;
            sp_unpack(a, ma, ea);
            sp_unpack(b, mb, eb);
            if (eb > ea)
            begin
                t = a; a = b; b = t;
                sp_unpack(a, ma, ea);
                sp_unpack(b, mb, eb);
            end
            big_s = a[31];
            sml_s = b[31];
            // Keep at most 60 guard bits; fold the rest of the small operand into a sticky bit.
            d = ea - eb;
            if (d > 60)
            begin
                rs    = d - 60;
                sml_m = (rs >= 24) ? 128'd0 : 128'(mb >> rs);
                if (mb != 0)
                    sml_m[0] = 1'b1;
                d = 60;
            end
            else
            begin
                sml_m = 128'(mb);
            end
            big_m = 128'(ma) << d;
            if (big_s == sml_s)
            begin
                sum  = big_m + sml_m;
                rsgn = big_s;
            end
            else if (big_m >= sml_m)
            begin
                sum  = big_m - sml_m;
                rsgn = big_s;
            end
            else
            begin
                sum  = sml_m - big_m;
                rsgn = sml_s;
            end
            if (sum == 0)
                rsgn = big_s & sml_s;
            return sp_round(rsgn, sum, ea - d);
        end
    endfunction

    function automatic logic [15:0] bf16_trunc(logic [31:0] a);
        return is_nan(a) ? BF16_QNAN : a[31:16];
    endfunction

    function automatic rot_pair_t rotate_pair(logic [63:0] d);
        logic [31:0] x0, x1, c, s;
        rot_pair_t   r;
        begin
            x0 = {d[15:0], 16'd0};
            x1 = {d[31:16], 16'd0};
            c  = {d[47:32], 16'd0};
            s  = {d[63:48], 16'd0};
            r.y_first  = bf16_trunc(sp_add(sp_mul(x0, c), sp_mul(x1, s) ^ 32'h8000_0000));
            r.y_second = bf16_trunc(sp_add(sp_mul(x0, s), sp_mul(x1, c)));
            return r;
        end
    endfunction

    assign pending        = rotated_q.size();
    assign fail_count     = fail_total;
    assign rotations_seen = seen_total;

    // Inputs only change at the rising edge, so the falling edge sees the handshake settled.
    always @(negedge clk)
    begin
        rot_pair_t exp_r, got;
        if (s_axis_tvalid && s_axis_tready)
            rotated_q.push_back(rotate_pair(s_axis_tdata));
        if (m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            seen_total++;
            if (rotated_q.size() == 0)
            begin
                $error("result transfer with nothing outstanding: %h", got);
                fail_total++;
            end
            else
            begin
                exp_r = rotated_q.pop_front();
                if (got.y_first !== exp_r.y_first)
                begin
                    $error("y_first expected %h actual %h", exp_r.y_first, got.y_first);
                    fail_total++;
                end
                if (got.y_second !== exp_r.y_second)
                begin
                    $error("y_second expected %h actual %h", exp_r.y_second, got.y_second);
                    fail_total++;
                end
            end
        end
    end

endmodule

/* sim/tb.sv */
`timescale 1ns / 100ps

module tb;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // x_first, x_second, cos_value, sin_value
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // y_first, y_second

    int fail_count;
    int pending;
    int rotations_seen;
    bit stim_done;

    localparam int N_RANDOM   = 930;
    localparam int HOLD_AT    = 200;  // result count at which the sink holds off
    localparam int HOLD_LEN   = 120;
    localparam int DRAIN_AT   = 500;  // item index where the source waits for a full drain

    rotary_embed_pair_bf16 i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    rotary_embed_pair_checker i_checker
    (
        .clk            (clk),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .fail_count     (fail_count),
        .pending        (pending),
        .rotations_seen (rotations_seen)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Draw a bf16 pattern: mostly ordinary magnitudes, some raw bits, some special encodings.
    function automatic logic [15:0] pick_bf16();
        int k;
        begin
            k = $urandom_range(0, 9);
            if (k < 5)
                return {1'($urandom), 8'($urandom_range(110, 140)), 7'($urandom)};
            if (k < 8)
                return 16'($urandom);
            if (k == 8)
                return {1'($urandom), 8'd0, 7'($urandom)};
            return {1'($urandom), 8'hFF, ($urandom_range(0, 1) != 0) ? 7'd0 : 7'($urandom)};
        end
    endfunction

    // Offer one pair, after an optional idle gap; keep tvalid high and wait for the transfer.
    task automatic send_pair(logic [15:0] x0, logic [15:0] x1, logic [15:0] c, logic [15:0] s);
        bit   took;
        int   gap;
        begin
            gap = $urandom_range(0, 10);
            if ($urandom_range(0, 3) == 0)
                gap = 0;  // back-to-back stretches
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= {s, c, x1, x0};
            do
            begin
                @(negedge clk);
                took = s_axis_tready;
                @(posedge clk);
            end while (!took);
        end
    endtask

    // Source: directed corners, then random pairs.
    initial
    begin
        logic [15:0] dir_vals [0:11];
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        stim_done     = 1'b0;
        rst_n         = 1'b0;
        dir_vals = '{16'h0000, 16'h8000, 16'h7F80, 16'hFF80, 16'h7FC0, 16'h0001,
                     16'h807F, 16'h7F7F, 16'hFF7F, 16'h3F80, 16'hBF80, 16'hFFFF};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Identity rotation and each special operand against ordinary values.
        send_pair(16'h3FC0, 16'h4040, 16'h3F80, 16'h0000);
        foreach (dir_vals[i])
            send_pair(dir_vals[i], dir_vals[(i + 5) % 12], dir_vals[(i + 3) % 12],
                      dir_vals[(i + 7) % 12]);
        // Exact cancellation gives +0; infinity minus infinity gives NaN.
        send_pair(16'h3F80, 16'h3F80, 16'h3F80, 16'h3F80);
        send_pair(16'h7F80, 16'h7F80, 16'h3F80, 16'h3F80);
        // Infinity times zero.
        send_pair(16'h7F80, 16'h0000, 16'h0000, 16'h3F80);
        // Overflow of a finite product.
        send_pair(16'h7F7F, 16'h7F7F, 16'h7F7F, 16'h7F7F);
        // Tiny products underflow into subnormals.
        send_pair(16'h0080, 16'h0081, 16'h3F00, 16'h3E80);
        send_pair(16'h1F80, 16'h1F00, 16'h2000, 16'h9F80);
        // Widely separated addends.
        send_pair(16'h5F80, 16'h2080, 16'h3F80, 16'h3F80);
        send_pair(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);

        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n == DRAIN_AT)
            begin
                // Hold the source until every outstanding result is back.
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
                while (pending != 0)
                    @(posedge clk);
            end
            send_pair(pick_bf16(), pick_bf16(), pick_bf16(), pick_bf16());
        end
        s_axis_tvalid <= 1'b0;
        stim_done     <= 1'b1;
    end

    // Sink: random hold-off per result, plus one long stall to back up the pipeline.
    initial
    begin
        bit took;
        bit held;
        m_axis_tready = 1'b0;
        held          = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!held && rotations_seen >= HOLD_AT)
            begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_LEN) @(posedge clk);
            end
            if ($urandom_range(0, 3) != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(0, 10)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
            begin
                @(negedge clk);
                took = m_axis_tvalid;
                @(posedge clk);
            end while (!took);
        end
    end

    // Verdict: drain, allow the pipeline latency to flush, then report.
    initial
    begin
        @(posedge stim_done);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        $display("Covered %0d rotated pairs: directed corners, random bf16 operands,",
                 rotations_seen);
        $display("one long output stall and one full drain of the pipeline.");
        if (fail_count == 0 && pending == 0)
            $display("rotary_embed_pair_bf16 verification clean");
        else
            $display("rotary_embed_pair_bf16 verification failed");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("rotary_embed_pair_bf16 verification failed");
        $finish;
    end

endmodule
